// ===== rtl/fsf_pkg.sv =====
// Shared types, constants and byte helpers for the fuzzy subsequence filter.
`default_nettype none
package fsf_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int LEN_W         = 6;
   localparam int SCORE_W       = 11;
   localparam int SUM_W         = SCORE_W + 1;

   localparam logic [SCORE_W-1:0] SCORE_MAX   = {SCORE_W{1'b1}};
   localparam logic [SCORE_W-1:0] BONUS_MATCH = SCORE_W'(16);
   localparam logic [SCORE_W-1:0] BONUS_RUN   = SCORE_W'(32);
   localparam logic [SCORE_W-1:0] BONUS_FIRST = SCORE_W'(32);
   localparam logic [SCORE_W-1:0] BONUS_SEP   = SCORE_W'(8);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_UP_U   = 8'h55;
   localparam logic [7:0] CH_LO_U   = 8'h75;
   localparam logic [7:0] CH_UP_W   = 8'h57;
   localparam logic [7:0] CH_LO_W   = 8'h77;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   typedef enum logic [1:0] {
      OP_ENTER = 2'd0,
      OP_KEY   = 2'd1,
      OP_BYTE  = 2'd2,
      OP_END   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KEY_CHAR  = 2'd0,
      KEY_ESC   = 2'd1,
      KEY_ENTER = 2'd2,
      KEY_BKSP  = 2'd3
   } key_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HAY,
      ST_BKSP,
      ST_WSPACE,
      ST_WWORD,
      ST_SEND
   } state_type;

   // scan context handed to the match unit
   typedef struct packed {
      logic               last_match;
      logic               first;
      logic               sep;
      logic [SCORE_W-1:0] score;
   } scan_ctx_type;

   // verdict returned by the match unit
   typedef struct packed {
      logic               hit;
      logic               upper;
      logic               space;
      logic [SCORE_W-1:0] score_next;
   } unit_out_type;

   function automatic logic is_upper_f(input logic [7:0] c);
      return (c >= CH_UP_A) && (c <= CH_UP_Z);
   endfunction

   function automatic logic is_space_f(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_sep_f(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_UNDER) || (c == CH_HYPHEN) || (c == CH_SLASH);
   endfunction

   function automatic logic [7:0] to_lower_f(input logic [7:0] c);
      return is_upper_f(c) ? c + CASE_GAP : c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/fuzzy_subsequence_filter.sv =====
// Top level of the fuzzy subsequence filter: sequencer, scan state and stream ports.
//
// Usage: requests arrive on req_* (tuser carries opcode, key kind and the ctrl
// flag, tdata the key or haystack byte). Opcode enter turns on pattern editing,
// key events edit the pattern, haystack bytes advance a greedy in-order match,
// and haystack end reports the score and rearms the scan. Every request except a
// haystack byte yields one response on rsp_* (tuser is the result kind).
// Sequencing: one request is in flight at a time. A haystack byte is taken without
// leaving idle when the pattern is empty or already found; otherwise the pattern
// memory is read, then the shared match unit compares and scores. Requests with a
// response pass through the send state to the output register; backspace first
// reads the last pattern byte. Ctrl-W walks the pattern backwards through the single
// memory read port, one byte per cycle, dropping spaces, then a word up to a space.
// Reset clears the pattern length, uppercase count, editing flag and scan state;
// the pattern memory itself is not cleared and needs no clearing pass.
// Stalls: the output register holds a response until rsp_tready; the block keeps
// accepting haystack bytes meanwhile and only waits in its send state when a
// second response is due before the first has been taken.
`default_nettype none
module fuzzy_subsequence_filter
   import fsf_pkg::*;
#(
   parameter int PATTERN_DEPTH = DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic [4:0]  req_tuser,   // opcode[1:0], key_kind[3:2], ctrl_held[4]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // handled[0], matched[1], match_score[12:2],
                                         // filter_active[13], pattern_length[19:14]
   output logic             rsp_tuser    // result_kind[0]
);

   localparam int AW     = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
   localparam int CW     = $clog2(PATTERN_DEPTH + 1);
   localparam int PAY_W  = 3 + SCORE_W + LEN_W;
   localparam int DATA_W = 24;

   // request fields
   opcode_type   req_opcode;
   key_kind_type req_kind;
   logic         req_ctrl;
   logic [7:0]   req_byte;

   assign req_opcode = opcode_type'(req_tuser[1:0]);
   assign req_kind   = key_kind_type'(req_tuser[3:2]);
   assign req_ctrl   = req_tuser[4];
   assign req_byte   = req_tdata;

   // sequencer and pattern state
   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      upper_ff, upper_in;
   logic               active_ff, active_in;

   // scan state
   logic [CW-1:0]      pos_ff, pos_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               last_ff, last_in;
   logic               first_ff, first_in;
   logic               sep_ff, sep_in;
   logic [7:0]         probe_ff, probe_in;
   logic               probe_sep_ff, probe_sep_in;

   // pending response
   logic               pend_kind_ff, pend_kind_in;
   logic               pend_handled_ff, pend_handled_in;
   logic               pend_matched_ff, pend_matched_in;
   logic [SCORE_W-1:0] pend_score_ff, pend_score_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [PAY_W-1:0]   rsp_data_ff, rsp_data_in;

   // memory and match unit hookup
   logic               mem_wr_en, mem_rd_en;
   logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
   logic [7:0]         mem_rd_data;
   scan_ctx_type       ctx;
   unit_out_type       verdict;

   logic               accept;
   logic               slot_free;
   logic [CW-1:0]      count_m1;
   logic [CW-1:0]      count_m2;

   fsf_pattern_store #(
      .DEPTH (PATTERN_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign ctx.last_match = last_ff;
   assign ctx.first      = first_ff;
   assign ctx.sep        = sep_ff;
   assign ctx.score      = score_ff;

   fsf_match_unit u_match (
      .stored  (mem_rd_data),
      .probe   (probe_ff),
      .ctx     (ctx),
      .verdict (verdict)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign count_m1   = count_ff - CW'(1);
   assign count_m2   = count_ff - CW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         upper_ff     <= '0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         score_ff     <= '0;
         last_ff      <= 1'b0;
         first_ff     <= 1'b1;
         sep_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         upper_ff     <= upper_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         score_ff     <= score_in;
         last_ff      <= last_in;
         first_ff     <= first_in;
         sep_ff       <= sep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      probe_ff        <= probe_in;
      probe_sep_ff    <= probe_sep_in;
      pend_kind_ff    <= pend_kind_in;
      pend_handled_ff <= pend_handled_in;
      pend_matched_ff <= pend_matched_in;
      pend_score_ff   <= pend_score_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_data_ff     <= rsp_data_in;
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      upper_in        = upper_ff;
      active_in       = active_ff;
      pos_in          = pos_ff;
      score_in        = score_ff;
      last_in         = last_ff;
      first_in        = first_ff;
      sep_in          = sep_ff;
      probe_in        = probe_ff;
      probe_sep_in    = probe_sep_ff;
      pend_kind_in    = pend_kind_ff;
      pend_handled_in = pend_handled_ff;
      pend_matched_in = pend_matched_ff;
      pend_score_in   = pend_score_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_data_in     = rsp_data_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = count_ff[AW-1:0];
      mem_rd_en       = 1'b0;
      mem_rd_addr     = pos_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // default response: key result, nothing handled
               pend_kind_in    = 1'b0;
               pend_handled_in = 1'b0;
               pend_matched_in = 1'b0;
               pend_score_in   = '0;
               state_in        = ST_SEND;
               unique case (req_opcode)
                  OP_ENTER: begin
                     active_in = 1'b1;
                  end
                  OP_BYTE: begin
                     state_in = ST_IDLE;
                     if ((count_ff != '0) && (pos_ff < count_ff)) begin
                        // fetch the next pattern byte, fold case when no capitals
                        mem_rd_en    = 1'b1;
                        mem_rd_addr  = pos_ff[AW-1:0];
                        probe_in     = (upper_ff == '0) ? to_lower_f(req_byte) : req_byte;
                        probe_sep_in = is_sep_f(req_byte);
                        state_in     = ST_HAY;
                     end
                  end
                  OP_END: begin
                     pend_kind_in = 1'b1;
                     if ((count_ff != '0) && (pos_ff == count_ff)) begin
                        pend_matched_in = 1'b1;
                        pend_score_in   = score_ff;
                     end
                     // rearm the scan
                     pos_in   = '0;
                     score_in = '0;
                     last_in  = 1'b0;
                     first_in = 1'b1;
                     sep_in   = 1'b0;
                  end
                  OP_KEY: begin
                     if (active_ff) begin
                        pend_handled_in = 1'b1;
                        unique case (req_kind)
                           KEY_ESC: begin
                              active_in = 1'b0;
                              count_in  = '0;
                              upper_in  = '0;
                           end
                           KEY_ENTER: begin
                              active_in = 1'b0;
                           end
                           KEY_BKSP: begin
                              if (count_ff != '0) begin
                                 mem_rd_en   = 1'b1;
                                 mem_rd_addr = count_m1[AW-1:0];
                                 state_in    = ST_BKSP;
                              end
                           end
                           KEY_CHAR: begin
                              if (req_ctrl && ((req_byte == CH_UP_U) || (req_byte == CH_LO_U))) begin
                                 count_in = '0;
                                 upper_in = '0;
                              end else if (req_ctrl &&
                                           ((req_byte == CH_UP_W) || (req_byte == CH_LO_W))) begin
                                 if (count_ff != '0) begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = count_m1[AW-1:0];
                                    state_in    = ST_WSPACE;
                                 end
                              end else if (!req_ctrl) begin
                                 // push, drop silently when full
                                 if (count_ff < CW'(PATTERN_DEPTH)) begin
                                    mem_wr_en = 1'b1;
                                    count_in  = count_ff + CW'(1);
                                    if (is_upper_f(req_byte)) begin
                                       upper_in = upper_ff + CW'(1);
                                    end
                                 end
                              end else begin
                                 pend_handled_in = 1'b0;
                              end
                           end
                           default: begin
                              pend_handled_in = 1'b0;
                           end
                        endcase
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_HAY: begin
            if (verdict.hit) begin
               score_in = verdict.score_next;
               last_in  = 1'b1;
               pos_in   = pos_ff + CW'(1);
            end else begin
               last_in  = 1'b0;
            end
            first_in = 1'b0;
            sep_in   = probe_sep_ff;
            state_in = ST_IDLE;
         end

         ST_BKSP: begin
            count_in = count_m1;
            if (verdict.upper && (upper_ff != '0)) begin
               upper_in = upper_ff - CW'(1);
            end
            state_in = ST_SEND;
         end

         ST_WSPACE, ST_WWORD: begin
            // word phase stops on a space and keeps it
            if ((state_ff == ST_WWORD) && verdict.space) begin
               state_in = ST_SEND;
            end else begin
               count_in = count_m1;
               if (verdict.upper && (upper_ff != '0)) begin
                  upper_in = upper_ff - CW'(1);
               end
               if (count_ff > CW'(1)) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = count_m2[AW-1:0];
                  state_in    = verdict.space ? ST_WSPACE : ST_WWORD;
               end else begin
                  state_in = ST_SEND;
               end
            end
         end

         ST_SEND: begin
            // hold the response until the output register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_data_in  = {LEN_W'(count_ff), active_ff, pend_score_ff,
                               pend_matched_ff, pend_handled_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {(DATA_W - PAY_W)'(0), rsp_data_ff};

   // pattern length never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PATTERN_DEPTH))
      else $error("pattern length beyond store depth");

   // capitals are a subset of the pattern
   a_upper_bound: assert property (@(posedge clock) disable iff (reset)
      upper_ff <= count_ff)
      else $error("uppercase count exceeds pattern length");

   // a haystack byte never leads straight into a response
   a_byte_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_BYTE)) |=> (state_ff != ST_SEND))
      else $error("haystack byte produced a response");

   // a response only appears after the send state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_SEND))
      else $error("response raised outside send state");

endmodule
`default_nettype wire

// ===== rtl/fsf_pattern_store.sv =====
// Pattern byte memory: one write port, one registered read port.
`default_nettype none
module fsf_pattern_store
   import fsf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/fsf_match_unit.sv =====
// Shared byte unit: classifies a stored byte, compares it and scores a hit.
`default_nettype none
module fsf_match_unit
   import fsf_pkg::*;
(
   input  wire logic [7:0]   stored,
   input  wire logic [7:0]   probe,
   input  wire scan_ctx_type ctx,
   output unit_out_type      verdict
);

   logic [SCORE_W-1:0] bonus;
   logic [SUM_W-1:0]   sum;

   always_comb begin
      bonus = BONUS_MATCH;
      if (ctx.last_match) begin
         bonus = bonus + BONUS_RUN;
      end
      if (ctx.first) begin
         bonus = bonus + BONUS_FIRST;
      end else if (ctx.sep) begin
         bonus = bonus + BONUS_SEP;
      end
      sum = SUM_W'(ctx.score) + SUM_W'(bonus);

      verdict.hit        = (stored == probe);
      verdict.upper      = is_upper_f(stored);
      verdict.space      = is_space_f(stored);
      // saturate at the top of the score range
      verdict.score_next = sum[SUM_W-1] ? SCORE_MAX : sum[SCORE_W-1:0];
   end

endmodule
`default_nettype wire
